@@ src/rnss_pkg.sv @@
// Shared types, microcode ROM and reaction tables for the reaction network stepper.
// No dependencies; used by reaction_network_ssa_step.
package rnss_pkg;

   localparam int NUM_SPECIES   = 11;
   localparam int NUM_REACTIONS = 20;
   localparam int COUNT_BITS    = 24;
   localparam int FRAC_BITS     = 24;
   localparam int RATE_FRAC     = 56;
   localparam int CA_FRAC       = 8;
   localparam int SPEC_W        = 4;
   localparam int RXN_W         = 5;
   localparam int PC_W          = 4;

   typedef logic [PC_W-1:0]   pc_type;
   typedef logic [SPEC_W-1:0] spec_type;
   typedef logic [RXN_W-1:0]  rxn_type;

   typedef enum logic [1:0] {F_NONE = 2'd0, F_AA = 2'd1, F_DAG = 2'd2, F_CA = 2'd3} fac_type;
   typedef enum logic [1:0] {
      MODE_LOAD = 2'd0, MODE_FIRE = 2'd1, MODE_EMIT = 2'd2, MODE_BAD = 2'd3
   } mode_type;
   typedef enum logic [2:0] {
      OP_IDLE = 3'd0, OP_LOAD = 3'd1, OP_FCHK = 3'd2, OP_FAPP = 3'd3,
      OP_POST = 3'd4, OP_CALC = 3'd5, OP_EMIT = 3'd6
   } uop_type;
   typedef enum logic [2:0] {
      C_NEXT = 3'd0, C_GOTO = 3'd1, C_DISPATCH = 3'd2, C_ERR = 3'd3, C_MORE = 3'd4
   } cond_type;
   typedef enum logic [1:0] {MUL_NONE = 2'd0, MUL_Y = 2'd1, MUL_PP = 2'd2} mul_type;
   typedef enum logic [1:0] {ACC_NONE = 2'd0, ACC_INIT = 2'd1, ACC_ADD = 2'd2} acc_type;
   typedef enum logic [1:0] {PP_LL = 2'd0, PP_LH = 2'd1, PP_HL = 2'd2, PP_HH = 2'd3} pp_type;

   localparam logic REG_AA  = 1'b0;
   localparam logic REG_DAG = 1'b1;

   typedef struct packed {
      uop_type  op;
      cond_type cond;
      pc_type   target;
      mul_type  mul;
      pp_type   mul_pp;
      acc_type  acc;
      pp_type   acc_pp;
   } ucw_type;

   typedef struct packed {
      logic [63:0] rate;
      spec_type    species;
      fac_type     factor;
   } term_type;

   localparam pc_type PC_IDLE = 4'd0;
   localparam pc_type PC_LOAD = 4'd1;
   localparam pc_type PC_FCHK = 4'd2;
   localparam pc_type PC_FAPP = 4'd3;
   localparam pc_type PC_POST = 4'd4;
   localparam pc_type PC_MULY = 4'd5;
   localparam pc_type PC_PP0  = 4'd6;
   localparam pc_type PC_PP1  = 4'd7;
   localparam pc_type PC_PP2  = 4'd8;
   localparam pc_type PC_PP3  = 4'd9;
   localparam pc_type PC_ACC  = 4'd10;
   localparam pc_type PC_EMIT = 4'd11;

   function automatic ucw_type ucode(input pc_type pc);
      ucw_type w;
      w = '{op: OP_CALC, cond: C_NEXT, target: PC_IDLE, mul: MUL_NONE, mul_pp: PP_LL,
            acc: ACC_NONE, acc_pp: PP_LL};
      unique case (pc)
         PC_IDLE: begin
            w.op = OP_IDLE; w.cond = C_DISPATCH;
         end
         PC_LOAD: begin
            w.op = OP_LOAD; w.cond = C_GOTO; w.target = PC_POST;
         end
         PC_FCHK: begin
            w.op = OP_FCHK; w.cond = C_ERR; w.target = PC_POST;
         end
         PC_FAPP: w.op = OP_FAPP;
         PC_POST: begin
            w.op = OP_POST; w.cond = C_GOTO; w.target = PC_IDLE;
         end
         PC_MULY: w.mul = MUL_Y;
         PC_PP0: begin
            w.mul = MUL_PP; w.mul_pp = PP_LL;
         end
         PC_PP1: begin
            w.mul = MUL_PP; w.mul_pp = PP_LH; w.acc = ACC_INIT; w.acc_pp = PP_LL;
         end
         PC_PP2: begin
            w.mul = MUL_PP; w.mul_pp = PP_HL; w.acc = ACC_ADD; w.acc_pp = PP_LH;
         end
         PC_PP3: begin
            w.mul = MUL_PP; w.mul_pp = PP_HH; w.acc = ACC_ADD; w.acc_pp = PP_HL;
         end
         PC_ACC: begin
            w.acc = ACC_ADD; w.acc_pp = PP_HH;
         end
         PC_EMIT: begin
            w.op = OP_EMIT; w.cond = C_MORE; w.target = PC_MULY;
         end
         default: begin
            w.cond = C_GOTO; w.target = PC_IDLE;
         end
      endcase
      return w;
   endfunction

   function automatic pc_type dispatch(input mode_type m);
      pc_type p;
      unique case (m)
         MODE_LOAD: p = PC_LOAD;
         MODE_FIRE: p = PC_FCHK;
         MODE_EMIT: p = PC_MULY;
         default:   p = PC_POST;
      endcase
      return p;
   endfunction

   // rate constants held with 56 fraction bits
   function automatic term_type term(input rxn_type r);
      term_type t;
      unique case (r)
         5'd0:  t = '{64'd72057594037927936,  4'd0,  F_NONE};
         5'd1:  t = '{64'd3602879701896396800, 4'd5, F_NONE};
         5'd2:  t = '{64'd8646911285,         4'd0,  F_AA};
         5'd3:  t = '{64'd7205759403792794,   4'd6,  F_NONE};
         5'd4:  t = '{64'd91549173225187443,  4'd1,  F_NONE};
         5'd5:  t = '{64'd252388928877246389, 4'd7,  F_NONE};
         5'd6:  t = '{64'd8646911285,         4'd1,  F_AA};
         5'd7:  t = '{64'd7205759403792794,   4'd8,  F_NONE};
         5'd8:  t = '{64'd72057594037927936,  4'd2,  F_NONE};
         5'd9:  t = '{64'd7205759403792794,   4'd9,  F_NONE};
         5'd10: t = '{64'd144115188075855872, 4'd3,  F_NONE};
         5'd11: t = '{64'd14411518807585587,  4'd4,  F_NONE};
         5'd12: t = '{64'd43234556422757,     4'd0,  F_CA};
         5'd13: t = '{64'd36028797018963968,  4'd1,  F_NONE};
         5'd14: t = '{64'd576316637115,       4'd1,  F_DAG};
         5'd15: t = '{64'd622202912998700142, 4'd2,  F_NONE};
         5'd16: t = '{64'd43234556423,        4'd0,  F_DAG};
         5'd17: t = '{64'd7205759403792794,   4'd10, F_NONE};
         5'd18: t = '{64'd1297036692683,      4'd10, F_AA};
         5'd19: t = '{64'd144115188075855872, 4'd3,  F_NONE};
         default: t = '{64'd0, 4'd0, F_NONE};
      endcase
      return t;
   endfunction

   function automatic spec_type dec_sp(input rxn_type r);
      spec_type s;
      unique case (r)
         5'd0, 5'd2, 5'd12, 5'd16: s = 4'd0;
         5'd4, 5'd6, 5'd13, 5'd14: s = 4'd1;
         5'd8, 5'd15:              s = 4'd2;
         5'd10, 5'd19:             s = 4'd3;
         5'd11:                    s = 4'd4;
         5'd1:                     s = 4'd5;
         5'd3:                     s = 4'd6;
         5'd5:                     s = 4'd7;
         5'd7:                     s = 4'd8;
         5'd9:                     s = 4'd9;
         5'd17, 5'd18:             s = 4'd10;
         default:                  s = 4'd0;
      endcase
      return s;
   endfunction

   function automatic spec_type inc_sp(input rxn_type r);
      spec_type s;
      unique case (r)
         5'd1, 5'd3, 5'd13, 5'd17: s = 4'd0;
         5'd5, 5'd7, 5'd12, 5'd15: s = 4'd1;
         5'd9, 5'd14:              s = 4'd2;
         5'd11, 5'd18:             s = 4'd3;
         5'd10:                    s = 4'd4;
         5'd0:                     s = 4'd5;
         5'd2:                     s = 4'd6;
         5'd4:                     s = 4'd7;
         5'd6:                     s = 4'd8;
         5'd8:                     s = 4'd9;
         5'd16, 5'd19:             s = 4'd10;
         default:                  s = 4'd0;
      endcase
      return s;
   endfunction

endpackage

@@ src/reaction_network_ssa_step.sv @@
// Reaction network stepper: species counts, fire logic and microcoded propensity sums.
// Depends on rnss_pkg (types, microcode ROM, reaction tables).
//
//  channel | role            | payload
//  req     | stream in       | tdata: reaction_index, species_index, species_count,
//          |                 |        calcium_level; tuser: mode
//  rsp     | stream out      | tdata: reaction_slot, cumulative_propensity;
//          |                 |        tuser: error_flag; tlast: last
//  csr     | APB registers   | 0x0 arachidonic_level, 0x4 diacylglycerol_level
//
// Load runs LOAD, POST; fire runs FCHK, FAPP, POST (FCHK to POST when rejected); emit runs
// MULY, PP0-PP3, ACC, EMIT per reaction: one shared 32x32 multiplier, five products per reaction.
// One item at a time; req_tready is high only while the sequencer sits at its idle step.
// Reset is synchronous: counts clear, levels return to 11000 and 5000.
// A stalled rsp holds the sequencer at its output step; the next sum is already computed.
module reaction_network_ssa_step #(
   parameter int COUNT_BITS = rnss_pkg::COUNT_BITS,
   parameter int FRAC_BITS  = rnss_pkg::FRAC_BITS
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // reaction_index[4:0], species_index[8:5], species_count[32:9], calcium_level[64:33]
   input  logic [71:0] req_tdata,
   // mode[1:0]
   input  logic [1:0]  req_tuser,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // reaction_slot[4:0], cumulative_propensity[68:5]
   output logic [71:0] rsp_tdata,
   // error_flag[0]
   output logic        rsp_tuser,
   output logic        rsp_tlast,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [2:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);

   localparam int S_PLAIN = rnss_pkg::RATE_FRAC - FRAC_BITS;
   localparam int S_CA    = S_PLAIN + rnss_pkg::CA_FRAC;
   localparam logic [127:0] BIAS_PLAIN = 128'd1 << (S_PLAIN - 1);
   localparam logic [127:0] BIAS_CA    = 128'd1 << (S_CA - 1);

   rnss_pkg::pc_type   pc_ff, pc_in;
   rnss_pkg::ucw_type  uw;
   rnss_pkg::term_type tm;
   rnss_pkg::rxn_type  r_ff, r_in;
   rnss_pkg::rxn_type  rix_ff, rix_in;
   rnss_pkg::spec_type six_ff, six_in;
   rnss_pkg::spec_type dec_ix, inc_ix;
   rnss_pkg::mode_type mode;

   logic [COUNT_BITS-1:0] load_ff, load_in;
   logic [COUNT_BITS-1:0] cnt_ff [rnss_pkg::NUM_SPECIES];
   logic [COUNT_BITS-1:0] cnt_in [rnss_pkg::NUM_SPECIES];
   logic [COUNT_BITS-1:0] x;
   logic [31:0]  ca_ff, ca_in;
   logic [23:0]  aa_ff, aa_in, dag_ff, dag_in;
   logic         err_ff, err_in;
   logic [63:0]  y_ff, y_in, prod_ff, prod_in, sum_ff, sum_in;
   logic [127:0] acc_ff, acc_in, prod_sh, acc_q;
   logic [31:0]  op_a, op_b;
   logic [63:0]  mul_out, term_v, sum_new;
   logic [64:0]  sum_w;

   logic         rsp_valid_ff, rsp_valid_in;
   logic [4:0]   rsp_slot_ff, rsp_slot_in;
   logic [63:0]  rsp_sum_ff, rsp_sum_in;
   logic         rsp_err_ff, rsp_err_in, rsp_last_ff, rsp_last_in;

   logic req_acc, out_free, stall, six_bad, fchk_err, r_last, csr_wr, out_load;

   assign uw       = rnss_pkg::ucode(pc_ff);
   assign tm       = rnss_pkg::term(r_ff);
   assign mode     = rnss_pkg::mode_type'(req_tuser);
   assign dec_ix   = rnss_pkg::dec_sp(rix_ff);
   assign inc_ix   = rnss_pkg::inc_sp(rix_ff);
   assign x        = cnt_ff[tm.species];

   assign req_tready = (pc_ff == rnss_pkg::PC_IDLE) && !reset;
   assign req_acc    = req_tvalid & req_tready;
   assign out_free   = ~rsp_valid_ff | rsp_tready;
   assign six_bad    = (six_ff >= 4'(rnss_pkg::NUM_SPECIES));
   assign fchk_err   = (rix_ff >= 5'(rnss_pkg::NUM_REACTIONS)) || (cnt_ff[dec_ix] == '0);
   assign r_last     = (r_ff == 5'(rnss_pkg::NUM_REACTIONS - 1));
   assign out_load   = ((uw.op == rnss_pkg::OP_POST) || (uw.op == rnss_pkg::OP_EMIT)) && out_free;
   assign stall      = ((uw.op == rnss_pkg::OP_IDLE) && !req_tvalid) ||
                       (((uw.op == rnss_pkg::OP_POST) || (uw.op == rnss_pkg::OP_EMIT)) &&
                        !out_free);

   always_comb begin
      if (stall) begin
         pc_in = pc_ff;
      end else begin
         case (uw.cond)
            rnss_pkg::C_GOTO:     pc_in = uw.target;
            rnss_pkg::C_DISPATCH: pc_in = rnss_pkg::dispatch(mode);
            rnss_pkg::C_ERR:      pc_in = fchk_err ? uw.target : pc_ff + 1'b1;
            rnss_pkg::C_MORE:     pc_in = r_last ? rnss_pkg::PC_IDLE : uw.target;
            default:              pc_in = pc_ff + 1'b1;
         endcase
      end
   end

   always_comb begin
      op_a = '0;
      op_b = '0;
      case (uw.mul)
         rnss_pkg::MUL_Y: begin
            op_a = 32'(x);
            case (tm.factor)
               rnss_pkg::F_AA:  op_b = 32'(aa_ff);
               rnss_pkg::F_DAG: op_b = 32'(dag_ff);
               rnss_pkg::F_CA:  op_b = ca_ff;
               default:         op_b = 32'd1;
            endcase
         end
         rnss_pkg::MUL_PP: begin
            op_a = (uw.mul_pp == rnss_pkg::PP_HL || uw.mul_pp == rnss_pkg::PP_HH) ?
                   tm.rate[63:32] : tm.rate[31:0];
            op_b = (uw.mul_pp == rnss_pkg::PP_LH || uw.mul_pp == rnss_pkg::PP_HH) ?
                   y_ff[63:32] : y_ff[31:0];
         end
         default: ;
      endcase
   end

   assign mul_out = op_a * op_b;
   assign y_in    = (uw.mul == rnss_pkg::MUL_Y) ? mul_out : y_ff;
   assign prod_in = (uw.mul == rnss_pkg::MUL_PP) ? mul_out : prod_ff;

   always_comb begin
      case (uw.acc_pp) inside
         rnss_pkg::PP_LL:                 prod_sh = {64'd0, prod_ff};
         rnss_pkg::PP_LH, rnss_pkg::PP_HL: prod_sh = {32'd0, prod_ff, 32'd0};
         default:                         prod_sh = {prod_ff, 64'd0};
      endcase
      case (uw.acc)
         rnss_pkg::ACC_INIT: acc_in = prod_sh +
                                      ((tm.factor == rnss_pkg::F_CA) ? BIAS_CA : BIAS_PLAIN);
         rnss_pkg::ACC_ADD:  acc_in = acc_ff + prod_sh;
         default:            acc_in = acc_ff;
      endcase
   end

   assign acc_q   = (tm.factor == rnss_pkg::F_CA) ? (acc_ff >> S_CA) : (acc_ff >> S_PLAIN);
   assign term_v  = (|acc_q[127:64]) ? '1 : acc_q[63:0];
   assign sum_w   = {1'b0, sum_ff} + {1'b0, term_v};
   assign sum_new = sum_w[64] ? '1 : sum_w[63:0];

   always_comb begin
      cnt_in  = cnt_ff;
      err_in  = err_ff;
      r_in    = r_ff;
      sum_in  = sum_ff;
      rix_in  = rix_ff;
      six_in  = six_ff;
      load_in = load_ff;
      ca_in   = ca_ff;
      if (req_acc) begin
         rix_in  = req_tdata[4:0];
         six_in  = req_tdata[8:5];
         load_in = COUNT_BITS'(req_tdata[32:9]);
         ca_in   = req_tdata[64:33];
         err_in  = (mode == rnss_pkg::MODE_BAD);
         r_in    = '0;
         sum_in  = '0;
      end
      case (uw.op)
         rnss_pkg::OP_LOAD: begin
            err_in = six_bad;
            if (!six_bad) begin
               cnt_in[six_ff] = load_ff;
            end
         end
         rnss_pkg::OP_FCHK: err_in = fchk_err;
         rnss_pkg::OP_FAPP: begin
            cnt_in[dec_ix] = cnt_ff[dec_ix] - 1'b1;
            if (cnt_ff[inc_ix] != '1) begin
               cnt_in[inc_ix] = cnt_ff[inc_ix] + 1'b1;
            end
         end
         rnss_pkg::OP_EMIT: begin
            if (out_free) begin
               sum_in = sum_new;
               r_in   = r_last ? '0 : r_ff + 1'b1;
            end
         end
         default: ;
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff & ~rsp_tready;
      rsp_slot_in  = rsp_slot_ff;
      rsp_sum_in   = rsp_sum_ff;
      rsp_err_in   = rsp_err_ff;
      rsp_last_in  = rsp_last_ff;
      if (out_load) begin
         rsp_valid_in = 1'b1;
         if (uw.op == rnss_pkg::OP_EMIT) begin
            rsp_slot_in = r_ff;
            rsp_sum_in  = sum_new;
            rsp_err_in  = 1'b0;
            rsp_last_in = r_last;
         end else begin
            rsp_slot_in = '0;
            rsp_sum_in  = '0;
            rsp_err_in  = err_ff;
            rsp_last_in = 1'b1;
         end
      end
   end

   assign csr_wr = csr_psel & csr_penable & csr_pwrite & csr_pready;
   assign aa_in  = (csr_wr && csr_paddr[2] == rnss_pkg::REG_AA)  ? csr_pwdata[23:0] : aa_ff;
   assign dag_in = (csr_wr && csr_paddr[2] == rnss_pkg::REG_DAG) ? csr_pwdata[23:0] : dag_ff;
   assign csr_prdata = (csr_paddr[2] == rnss_pkg::REG_DAG) ? {8'd0, dag_ff} : {8'd0, aa_ff};
   assign csr_pready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         pc_ff        <= rnss_pkg::PC_IDLE;
         r_ff         <= '0;
         err_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
         aa_ff        <= 24'd11000;
         dag_ff       <= 24'd5000;
         for (int i = 0; i < rnss_pkg::NUM_SPECIES; i++) begin
            cnt_ff[i] <= '0;
         end
      end else begin
         pc_ff        <= pc_in;
         r_ff         <= r_in;
         err_ff       <= err_in;
         rsp_valid_ff <= rsp_valid_in;
         aa_ff        <= aa_in;
         dag_ff       <= dag_in;
         cnt_ff       <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      rix_ff      <= rix_in;
      six_ff      <= six_in;
      load_ff     <= load_in;
      ca_ff       <= ca_in;
      y_ff        <= y_in;
      prod_ff     <= prod_in;
      acc_ff      <= acc_in;
      sum_ff      <= sum_in;
      rsp_slot_ff <= rsp_slot_in;
      rsp_sum_ff  <= rsp_sum_in;
      rsp_err_ff  <= rsp_err_in;
      rsp_last_ff <= rsp_last_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {3'd0, rsp_sum_ff, rsp_slot_ff};
   assign rsp_tuser  = rsp_err_ff;
   assign rsp_tlast  = rsp_last_ff;

   a_accept_leaves_idle: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> pc_ff != rnss_pkg::PC_IDLE)
      else $error("sequencer stayed idle after accepting a word");

   a_error_word_empty: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser |-> rsp_tlast && rsp_tdata == '0)
      else $error("error word carries payload or is not last");

   a_slot_range: assert property (@(posedge clock) disable iff (reset)
      r_ff < 5'(rnss_pkg::NUM_REACTIONS))
      else $error("reaction counter out of range");

   a_fire_no_underflow: assert property (@(posedge clock) disable iff (reset)
      pc_ff == rnss_pkg::PC_FAPP |-> cnt_ff[dec_ix] != '0 && !err_ff)
      else $error("fire applied to an empty count");

endmodule

@@ verif/tb_reaction_network_ssa_step.sv @@
`timescale 1ns / 1ps
// Self-checking bench for reaction_network_ssa_step: species loads, reaction firing and
// propensity sums streamed over req/rsp, levels set over csr, checked against an in-bench model.
// Depends on rnss_pkg and the reaction_network_ssa_step RTL.
module tb_reaction_network_ssa_step;

   localparam int STALL_LIMIT = 2000;
   localparam int ITEMS_PER_PHASE = 80;
   localparam int PHASES = 6;
   localparam int TERM_SHIFT = rnss_pkg::RATE_FRAC - rnss_pkg::FRAC_BITS;
   localparam int CA_SHIFT = rnss_pkg::RATE_FRAC + rnss_pkg::CA_FRAC - rnss_pkg::FRAC_BITS;
   localparam logic [2:0] AA_ADDR = {rnss_pkg::REG_AA, 2'b00};
   localparam logic [2:0] DAG_ADDR = {rnss_pkg::REG_DAG, 2'b00};

   typedef struct packed {
      rnss_pkg::mode_type mode;
      logic [4:0]  reaction;
      logic [3:0]  species;
      logic [23:0] count;
      logic [31:0] calcium;
   } req_item_type;

   typedef struct packed {
      logic [4:0]  slot;
      logic [63:0] sum;
      logic        error_flag;
      logic        last;
   } result_word_type;

   typedef struct packed {
      logic [63:0] rate;
      logic [3:0]  reactant;
      logic [3:0]  product;
      rnss_pkg::fac_type factor;
   } rxn_row_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   // reaction_index[4:0], species_index[8:5], species_count[32:9], calcium_level[64:33]
   logic [71:0] req_tdata = '0;
   // mode[1:0]
   logic [1:0]  req_tuser = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   // reaction_slot[4:0], cumulative_propensity[68:5]
   logic [71:0] rsp_tdata;
   // error_flag[0]
   logic        rsp_tuser;
   logic        rsp_tlast;
   logic        csr_psel = 1'b0;
   logic        csr_penable = 1'b0;
   logic        csr_pwrite = 1'b0;
   logic [2:0]  csr_paddr = '0;
   logic [31:0] csr_pwdata = '0;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   logic [rnss_pkg::COUNT_BITS-1:0] population [rnss_pkg::NUM_SPECIES] = '{default: '0};
   logic [23:0]     aa_level = 24'd11000;
   logic [23:0]     dag_level = 24'd5000;
   req_item_type    req_backlog [$];
   result_word_type propensity_words [$];
   req_item_type    req_head;
   result_word_type rsp_want;
   bit              req_quiet = 1'b0;
   bit              rsp_quiet = 1'b0;
   bit              progress;
   int              req_gap = 0;
   int              rsp_hold = 0;
   int              items_queued = 0;
   int              items_sent = 0;
   int              items_taken = 0;
   int              idle_cycles = 0;
   int              field_errors = 0;

   reaction_network_ssa_step uut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
      .rsp_tuser(rsp_tuser), .rsp_tlast(rsp_tlast),
      .csr_psel(csr_psel), .csr_penable(csr_penable), .csr_pwrite(csr_pwrite),
      .csr_paddr(csr_paddr), .csr_pwdata(csr_pwdata), .csr_prdata(csr_prdata),
      .csr_pready(csr_pready)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   function automatic rxn_row_type rxn_row(input logic [4:0] r);
      rxn_row_type row;
      case (r)
         5'd0:  row = '{64'd72057594037927936,   4'd0,  4'd5,  rnss_pkg::F_NONE};
         5'd1:  row = '{64'd3602879701896396800, 4'd5,  4'd0,  rnss_pkg::F_NONE};
         5'd2:  row = '{64'd8646911285,          4'd0,  4'd6,  rnss_pkg::F_AA};
         5'd3:  row = '{64'd7205759403792794,    4'd6,  4'd0,  rnss_pkg::F_NONE};
         5'd4:  row = '{64'd91549173225187443,   4'd1,  4'd7,  rnss_pkg::F_NONE};
         5'd5:  row = '{64'd252388928877246389,  4'd7,  4'd1,  rnss_pkg::F_NONE};
         5'd6:  row = '{64'd8646911285,          4'd1,  4'd8,  rnss_pkg::F_AA};
         5'd7:  row = '{64'd7205759403792794,    4'd8,  4'd1,  rnss_pkg::F_NONE};
         5'd8:  row = '{64'd72057594037927936,   4'd2,  4'd9,  rnss_pkg::F_NONE};
         5'd9:  row = '{64'd7205759403792794,    4'd9,  4'd2,  rnss_pkg::F_NONE};
         5'd10: row = '{64'd144115188075855872,  4'd3,  4'd4,  rnss_pkg::F_NONE};
         5'd11: row = '{64'd14411518807585587,   4'd4,  4'd3,  rnss_pkg::F_NONE};
         5'd12: row = '{64'd43234556422757,      4'd0,  4'd1,  rnss_pkg::F_CA};
         5'd13: row = '{64'd36028797018963968,   4'd1,  4'd0,  rnss_pkg::F_NONE};
         5'd14: row = '{64'd576316637115,        4'd1,  4'd2,  rnss_pkg::F_DAG};
         5'd15: row = '{64'd622202912998700142,  4'd2,  4'd1,  rnss_pkg::F_NONE};
         5'd16: row = '{64'd43234556423,         4'd0,  4'd10, rnss_pkg::F_DAG};
         5'd17: row = '{64'd7205759403792794,    4'd10, 4'd0,  rnss_pkg::F_NONE};
         5'd18: row = '{64'd1297036692683,       4'd10, 4'd3,  rnss_pkg::F_AA};
         5'd19: row = '{64'd144115188075855872,  4'd3,  4'd10, rnss_pkg::F_NONE};
         default: row = '{64'd0, 4'd0, 4'd0, rnss_pkg::F_NONE};
      endcase
      return row;
   endfunction

   // round half up after the shift, saturate to 64 bits
   function automatic logic [63:0] scaled_product(input logic [63:0] a, input logic [63:0] b,
                                                  input int sh);
      logic [127:0] p;
      p = {64'd0, a} * {64'd0, b};
      p = (p + (128'd1 << (sh - 1))) >> sh;
      if (p[127:64] != 64'd0)
         return '1;
      return p[63:0];
   endfunction

   task automatic network_step(input req_item_type it);
      rxn_row_type     row;
      result_word_type w;
      logic [63:0]     x;
      logic [63:0]     addend;
      logic [63:0]     sum;
      int              r;
      w = '{slot: 5'd0, sum: 64'd0, error_flag: 1'b1, last: 1'b1};
      case (it.mode)
         rnss_pkg::MODE_LOAD: begin
            if (it.species < rnss_pkg::NUM_SPECIES) begin
               population[it.species] = it.count;
               w.error_flag = 1'b0;
            end
         end
         rnss_pkg::MODE_FIRE: begin
            if (it.reaction < rnss_pkg::NUM_REACTIONS) begin
               row = rxn_row(it.reaction);
               if (population[row.reactant] != '0) begin
                  population[row.reactant] = population[row.reactant] - 1'b1;
                  if (population[row.product] != '1)
                     population[row.product] = population[row.product] + 1'b1;
                  w.error_flag = 1'b0;
               end
            end
         end
         rnss_pkg::MODE_EMIT: begin
            sum = 64'd0;
            for (r = 0; r < rnss_pkg::NUM_REACTIONS; r++) begin
               row = rxn_row(r[4:0]);
               x = {{(64 - rnss_pkg::COUNT_BITS){1'b0}}, population[row.reactant]};
               case (row.factor)
                  rnss_pkg::F_AA:  addend = scaled_product(row.rate, x * aa_level, TERM_SHIFT);
                  rnss_pkg::F_DAG: addend = scaled_product(row.rate, x * dag_level, TERM_SHIFT);
                  rnss_pkg::F_CA:  addend = scaled_product(row.rate, x * it.calcium, CA_SHIFT);
                  default:         addend = scaled_product(row.rate, x, TERM_SHIFT);
               endcase
               sum = (64'hFFFF_FFFF_FFFF_FFFF - sum < addend) ? '1 : sum + addend;
               w = '{slot: r[4:0], sum: sum, error_flag: 1'b0,
                     last: (r == rnss_pkg::NUM_REACTIONS - 1)};
               propensity_words.push_back(w);
            end
         end
         default: ;
      endcase
      if (it.mode != rnss_pkg::MODE_EMIT)
         propensity_words.push_back(w);
   endtask

   function automatic int idle_span(input bit quiet);
      int pick;
      pick = $urandom_range(0, 99);
      if (quiet || pick < 55)
         return 0;
      if (pick < 92)
         return $urandom_range(1, 3);
      return $urandom_range(4, 40);
   endfunction

   always @(negedge clock) begin
      if (!reset && (!req_tvalid || items_taken == items_sent)) begin
         if (req_gap > 0 || req_backlog.size() == 0) begin
            if (req_gap > 0)
               req_gap--;
            req_tvalid <= 1'b0;
         end else begin
            req_head = req_backlog.pop_front();
            items_sent++;
            req_tdata <= {7'd0, req_head.calcium, req_head.count, req_head.species,
                          req_head.reaction};
            req_tuser <= req_head.mode;
            req_tvalid <= 1'b1;
            if ($urandom_range(0, 31) == 0)
               req_quiet = !req_quiet;
            req_gap = idle_span(req_quiet);
         end
      end
   end

   always @(negedge clock) begin
      if (rsp_hold > 0) begin
         rsp_hold--;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= 1'b1;
         if ($urandom_range(0, 31) == 0)
            rsp_quiet = !rsp_quiet;
         rsp_hold = idle_span(rsp_quiet);
      end
   end

   always @(posedge clock) begin
      if (!reset) begin
         progress = 1'b0;
         if (req_tvalid && req_tready) begin
            network_step(req_head);
            items_taken++;
            progress = 1'b1;
         end
         if (rsp_tvalid && rsp_tready) begin
            progress = 1'b1;
            if (propensity_words.size() == 0) begin
               $error("result word with none predicted: tdata %h", rsp_tdata);
               field_errors++;
            end else begin
               rsp_want = propensity_words.pop_front();
               if (rsp_tdata[4:0] !== rsp_want.slot) begin
                  $error("reaction_slot: expected %0d, got %0d", rsp_want.slot,
                         rsp_tdata[4:0]);
                  field_errors++;
               end
               if (rsp_tdata[68:5] !== rsp_want.sum) begin
                  $error("cumulative_propensity: expected %0d, got %0d", rsp_want.sum,
                         rsp_tdata[68:5]);
                  field_errors++;
               end
               if (rsp_tuser !== rsp_want.error_flag) begin
                  $error("error_flag: expected %0d, got %0d", rsp_want.error_flag,
                         rsp_tuser);
                  field_errors++;
               end
               if (rsp_tlast !== rsp_want.last) begin
                  $error("last: expected %0d, got %0d", rsp_want.last, rsp_tlast);
                  field_errors++;
               end
            end
         end
         idle_cycles = progress ? 0 : idle_cycles + 1;
         if (idle_cycles >= STALL_LIMIT) begin
            $display("Mismatches found");
            $finish;
         end
      end
   end

   task automatic queue_item(input rnss_pkg::mode_type mode, input logic [4:0] reaction,
                             input logic [3:0] species, input logic [23:0] count,
                             input logic [31:0] calcium);
      req_backlog.push_back('{mode, reaction, species, count, calcium});
      items_queued++;
   endtask

   task automatic queue_random_item();
      logic [4:0]  reaction;
      logic [3:0]  species;
      logic [23:0] count;
      logic [31:0] calcium;
      rnss_pkg::mode_type mode;
      int          pick;
      reaction = 5'($urandom_range(0, 31));
      species = 4'($urandom_range(0, 15));
      count = 24'($urandom);
      calcium = $urandom;
      pick = $urandom_range(0, 99);
      if (pick < 30) begin
         mode = rnss_pkg::MODE_LOAD;
         if ($urandom_range(0, 9) != 0)
            species = 4'($urandom_range(0, rnss_pkg::NUM_SPECIES - 1));
         case ($urandom_range(0, 4))
            0: count = 24'($urandom_range(0, 3));
            1: count = '1;
            2: count = 24'($urandom_range(1, 40));
            3: count = 24'hFFFFFF - 24'($urandom_range(0, 3));
            default: ;
         endcase
      end else if (pick < 75) begin
         mode = rnss_pkg::MODE_FIRE;
         if ($urandom_range(0, 9) != 0)
            reaction = 5'($urandom_range(0, rnss_pkg::NUM_REACTIONS - 1));
      end else if (pick < 93) begin
         mode = rnss_pkg::MODE_EMIT;
         if ($urandom_range(0, 3) == 0)
            calcium = $urandom_range(0, 4096);
      end else begin
         mode = rnss_pkg::MODE_BAD;
      end
      queue_item(mode, reaction, species, count, calcium);
   endtask

   task automatic wait_drained();
      @(negedge clock);
      while (items_taken != items_queued || propensity_words.size() != 0)
         @(negedge clock);
   endtask

   task automatic csr_write(input logic [2:0] addr, input logic [31:0] value);
      @(negedge clock);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= addr;
      csr_pwdata <= value;
      @(negedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready)
         @(posedge clock);
      @(negedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      if (addr == AA_ADDR)
         aa_level = value[23:0];
      else
         dag_level = value[23:0];
   endtask

   initial begin
      logic [31:0] aa_word;
      logic [31:0] dag_word;
      int          s;
      int          phase;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      queue_item(rnss_pkg::MODE_EMIT, 5'd0, 4'd0, 24'd0, 32'd0);
      queue_item(rnss_pkg::MODE_LOAD, 5'd31, 4'd11, 24'hFFFFFF, 32'hFFFFFFFF);
      queue_item(rnss_pkg::MODE_LOAD, 5'd0, 4'd15, 24'd7, 32'd0);
      queue_item(rnss_pkg::MODE_FIRE, 5'd0, 4'd0, 24'd0, 32'd0);
      queue_item(rnss_pkg::MODE_FIRE, 5'd20, 4'd0, 24'd0, 32'd0);
      queue_item(rnss_pkg::MODE_FIRE, 5'd31, 4'd15, 24'hFFFFFF, 32'hFFFFFFFF);
      queue_item(rnss_pkg::MODE_BAD, 5'd31, 4'd15, 24'hFFFFFF, 32'hFFFFFFFF);
      for (s = 0; s < rnss_pkg::NUM_SPECIES; s++)
         queue_item(rnss_pkg::MODE_LOAD, 5'($urandom_range(0, 31)), s[3:0],
                    (s == 0 || s == 5) ? 24'hFFFFFF : 24'($urandom_range(1, 5000)), $urandom);
      // product side already at full scale
      queue_item(rnss_pkg::MODE_FIRE, 5'd0, 4'd0, 24'd0, 32'd0);
      queue_item(rnss_pkg::MODE_EMIT, 5'd0, 4'd0, 24'd0, 32'hFFFFFFFF);
      queue_item(rnss_pkg::MODE_FIRE, 5'd19, 4'd0, 24'd0, 32'd0);
      queue_item(rnss_pkg::MODE_EMIT, 5'd0, 4'd0, 24'd0, $urandom);
      wait_drained();

      for (phase = 0; phase < PHASES; phase++) begin
         case (phase)
            0: begin
               aa_word = 32'hFFFFFFFF;
               dag_word = 32'hFFFFFFFF;
            end
            1: begin
               aa_word = 32'd0;
               dag_word = 32'd0;
            end
            3: begin
               aa_word = 32'd0;
               dag_word = 32'h00FFFFFF;
            end
            4: begin
               aa_word = 32'h00FFFFFF;
               dag_word = 32'd0;
            end
            default: begin
               aa_word = $urandom;
               dag_word = $urandom;
            end
         endcase
         csr_write(AA_ADDR, aa_word);
         csr_write(DAG_ADDR, dag_word);
         repeat (ITEMS_PER_PHASE) queue_random_item();
         wait_drained();
      end

      repeat (150) @(posedge clock);
      if (field_errors == 0)
         $display("No mismatches found");
      else
         $display("Mismatches found");
      $finish;
   end

endmodule
